/* hw/rtl/pooling_window_tap_addresser_defines.svh */
// Assertion helpers for the files that check their own logic.
// Both expect a clock named i_clk and an active-low reset named i_rst_n.
`ifndef POOLING_WINDOW_TAP_ADDRESSER_DEFINES_SVH
`define POOLING_WINDOW_TAP_ADDRESSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PWTA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PWTA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* hw/rtl/pwta_pkg.sv */
package pwta_pkg;

    localparam int MAX_DIM      = 256;
    localparam int MAX_CHANNELS = 256;
    localparam int MAX_WINDOW   = 8;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 3;
    localparam int INDEX_W   = 24;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCOUNT_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_SAME   = 3'd7;

    typedef struct packed {
        logic [8:0] image_width;
        logic [8:0] image_height;
        logic [8:0] channel_count;
        logic [3:0] window_width;
        logic [3:0] window_height;
        logic [3:0] step_x;
        logic [3:0] step_y;
        logic       border_same;
    } t_cfg;

    // One classified position: either an out-of-range marker or a clipped
    // window given by its first index and its extent minus one.
    typedef struct packed {
        logic               inv;
        logic [INDEX_W-1:0] base;
        logic [2:0]         ncols_m1;
        logic [2:0]         nrows_m1;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_push;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

endpackage

/* hw/rtl/pwta_front.sv */
module pwta_front
    import pwta_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  logic [7:0] i_out_col,
    input  logic [7:0] i_out_row,
    input  logic [7:0] i_channel,
    output logic       o_stall,
    output t_push      o_push,
    input  logic       i_q_full
);

    logic        r_a_valid;
    logic [11:0] r_a_org_x;
    logic [11:0] r_a_org_y;
    logic [16:0] r_a_chh;
    logic        r_a_ch_ok;

    logic        r_b_valid;
    logic        r_b_inv;
    logic [16:0] r_b_row_start;
    logic [7:0]  r_b_x_off;
    logic [2:0]  r_b_ncols_m1;
    logic [2:0]  r_b_nrows_m1;

    logic b_free;
    logic a_free;
    logic accept;
    logic push;

    logic        cfg_ok;
    logic [3:0]  pad_w;
    logic [3:0]  pad_h;
    logic [3:0]  left;
    logic [3:0]  top;
    logic [9:0]  sum_x;
    logic [9:0]  sum_y;
    logic        fits_x;
    logic        fits_y;
    logic [12:0] win_end_x;
    logic [12:0] win_end_y;
    logic [12:0] img_end_x;
    logic [12:0] img_end_y;
    logic        pos_x_ok;
    logic        pos_y_ok;
    logic [11:0] x_lo;
    logic [11:0] y_lo;
    logic [12:0] x_hi;
    logic [12:0] y_hi;
    logic [12:0] ncols;
    logic [12:0] nrows;
    logic [11:0] x_off;
    logic [11:0] y_off;
    logic        b_inv;
    logic [25:0] base_full;

    assign push   = r_b_valid && !i_q_full;
    assign b_free = !r_b_valid || push;
    assign a_free = !r_a_valid || b_free;
    assign accept = i_valid && a_free;
    assign o_stall = !a_free;

    // Register limits; the steps have no upper bound beyond their width.
    assign cfg_ok = (i_cfg.image_width != '0) && (i_cfg.image_width <= 9'(MAX_DIM)) &&
                    (i_cfg.image_height != '0) && (i_cfg.image_height <= 9'(MAX_DIM)) &&
                    (i_cfg.channel_count != '0) &&
                    (i_cfg.channel_count <= 9'(MAX_CHANNELS)) &&
                    (i_cfg.window_width != '0) && (i_cfg.window_width <= 4'(MAX_WINDOW)) &&
                    (i_cfg.window_height != '0) && (i_cfg.window_height <= 4'(MAX_WINDOW)) &&
                    (i_cfg.step_x != '0) && (i_cfg.step_y != '0);

    always_comb begin
        pad_w = i_cfg.border_same ? (i_cfg.window_width - 4'd1) : 4'd0;
        pad_h = i_cfg.border_same ? (i_cfg.window_height - 4'd1) : 4'd0;
        left  = {1'b0, pad_w[3:1]};
        top   = {1'b0, pad_h[3:1]};

        sum_x  = {1'b0, i_cfg.image_width} + 10'(pad_w);
        sum_y  = {1'b0, i_cfg.image_height} + 10'(pad_h);
        fits_x = sum_x >= 10'(i_cfg.window_width);
        fits_y = sum_y >= 10'(i_cfg.window_height);

        // col < (sum - win) / step + 1 is the same as col * step + win <= sum.
        win_end_x = 13'(r_a_org_x) + 13'(i_cfg.window_width);
        win_end_y = 13'(r_a_org_y) + 13'(i_cfg.window_height);
        pos_x_ok  = win_end_x <= 13'(sum_x);
        pos_y_ok  = win_end_y <= 13'(sum_y);

        // Clip the window to the image, all in padded coordinates.
        img_end_x = 13'(left) + 13'(i_cfg.image_width);
        img_end_y = 13'(top) + 13'(i_cfg.image_height);
        x_lo  = (r_a_org_x > 12'(left)) ? r_a_org_x : 12'(left);
        y_lo  = (r_a_org_y > 12'(top)) ? r_a_org_y : 12'(top);
        x_hi  = (win_end_x < img_end_x) ? win_end_x : img_end_x;
        y_hi  = (win_end_y < img_end_y) ? win_end_y : img_end_y;
        ncols = x_hi - 13'(x_lo) - 13'd1;
        nrows = y_hi - 13'(y_lo) - 13'd1;
        x_off = x_lo - 12'(left);
        y_off = y_lo - 12'(top);

        b_inv = !(cfg_ok && fits_x && fits_y && pos_x_ok && pos_y_ok && r_a_ch_ok);

        base_full = 26'(r_b_row_start) * 26'(i_cfg.image_width) + 26'(r_b_x_off);

        o_push.valid         = push;
        o_push.desc.inv      = r_b_inv;
        o_push.desc.base     = base_full[INDEX_W-1:0];
        o_push.desc.ncols_m1 = r_b_ncols_m1;
        o_push.desc.nrows_m1 = r_b_nrows_m1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= i_valid;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_org_x <= 12'(i_out_col) * 12'(i_cfg.step_x);
            r_a_org_y <= 12'(i_out_row) * 12'(i_cfg.step_y);
            r_a_chh   <= 17'(i_channel) * 17'(i_cfg.image_height);
            r_a_ch_ok <= 9'(i_channel) < i_cfg.channel_count;
        end
        if (b_free && r_a_valid) begin
            r_b_inv       <= b_inv;
            r_b_row_start <= r_a_chh + 17'(y_off);
            r_b_x_off     <= x_off[7:0];
            r_b_ncols_m1  <= ncols[2:0];
            r_b_nrows_m1  <= nrows[2:0];
        end
    end

endmodule

/* hw/rtl/pwta_queue.sv */
module pwta_queue
    import pwta_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output t_desc o_head,
    output logic  o_full,
    output logic  o_empty
);

    t_desc                r_mem [QDEPTH];
    logic [QPTR_W-1:0]    r_wr_ptr;
    logic [QPTR_W-1:0]    r_rd_ptr;
    logic [QCOUNT_W-1:0]  r_count;
    logic [QPTR_W-1:0]    n_wr_ptr;
    logic [QPTR_W-1:0]    n_rd_ptr;
    logic [QCOUNT_W-1:0]  n_count;

    assign o_full  = r_count == QCOUNT_W'(QDEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = r_wr_ptr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + QPTR_W'(1);
        end
        case ({i_push.valid, i_pop})
            2'b10:   n_count = r_count + QCOUNT_W'(1);
            2'b01:   n_count = r_count - QCOUNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.desc;
        end
    end

endmodule

/* hw/rtl/pwta_back.sv */
module pwta_back
    import pwta_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_desc              i_head,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [INDEX_W-1:0] o_tap_index,
    output logic               o_tap_valid,
    output logic               o_last_tap
);

    t_back_state        r_state;
    t_back_state        n_state;
    logic               r_inv;
    logic [INDEX_W-1:0] r_idx;
    logic [INDEX_W-1:0] r_row_base;
    logic [2:0]         r_ncols_m1;
    logic [2:0]         r_col_cnt;
    logic [2:0]         r_row_cnt;
    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_index;
    logic               r_out_tap_valid;
    logic               r_out_last;

    logic               n_inv;
    logic [INDEX_W-1:0] n_idx;
    logic [INDEX_W-1:0] n_row_base;
    logic [2:0]         n_ncols_m1;
    logic [2:0]         n_col_cnt;
    logic [2:0]         n_row_cnt;
    logic               n_out_valid;

    logic               out_free;
    logic               emit;
    logic               is_last;
    logic [INDEX_W-1:0] next_row;

    assign out_free = !r_out_valid || !i_stall;
    assign is_last  = r_inv || ((r_col_cnt == '0) && (r_row_cnt == '0));
    assign emit     = (r_state == BK_RUN) && out_free;
    assign next_row = r_row_base + INDEX_W'(i_cfg.image_width);

    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        n_inv       = r_inv;
        n_idx       = r_idx;
        n_row_base  = r_row_base;
        n_ncols_m1  = r_ncols_m1;
        n_col_cnt   = r_col_cnt;
        n_row_cnt   = r_row_cnt;
        n_out_valid = r_out_valid && i_stall;

        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (emit) begin
                    n_out_valid = 1'b1;
                    if (is_last) begin
                        // Chain straight into the next position when one waits.
                        o_pop   = !i_empty;
                        n_state = i_empty ? BK_IDLE : BK_RUN;
                    end else if (r_col_cnt != '0) begin
                        n_idx     = r_idx + INDEX_W'(1);
                        n_col_cnt = r_col_cnt - 3'd1;
                    end else begin
                        n_row_base = next_row;
                        n_idx      = next_row;
                        n_col_cnt  = r_ncols_m1;
                        n_row_cnt  = r_row_cnt - 3'd1;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        if (o_pop) begin
            n_inv      = i_head.inv;
            n_idx      = i_head.base;
            n_row_base = i_head.base;
            n_ncols_m1 = i_head.ncols_m1;
            n_col_cnt  = i_head.ncols_m1;
            n_row_cnt  = i_head.nrows_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inv      <= n_inv;
        r_idx      <= n_idx;
        r_row_base <= n_row_base;
        r_ncols_m1 <= n_ncols_m1;
        r_col_cnt  <= n_col_cnt;
        r_row_cnt  <= n_row_cnt;
        if (emit) begin
            r_out_index     <= r_inv ? '0 : r_idx;
            r_out_tap_valid <= !r_inv;
            r_out_last      <= is_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_tap_index = r_out_index;
    assign o_tap_valid = r_out_tap_valid;
    assign o_last_tap  = r_out_last;

endmodule

/* hw/rtl/pooling_window_tap_addresser.sv */
// Pooling window tap addresser.
// Input channel (i_valid / o_stall) takes one pooling output position per beat:
// column, row and channel. Output channel (o_valid / i_stall) gives one beat per
// window tap inside the image, in row-major window order, each carrying the
// linear input index; the final beat of a position has o_last_tap set. A position
// that is out of range, or any position under a configuration with no outputs,
// gives a single beat with o_tap_valid low, index zero and o_last_tap set.
// On its way to the output an item passes the two front-end stages and the queue,
// is popped into the back-end tap counter, and each beat is registered at the output.
// The tap counter emits one output beat per cycle while the receiver does not stall,
// one for each tap of an item (a single beat for an out-of-range position), and
// chains straight into the next item when one waits in the queue. The front end
// classifies in two stages and hands off through a four-entry queue, so it keeps
// taking items while the back end is busy.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the user must
// write it only while idle, as the block does not enforce this. Reset restores the
// default registers and empties the stages and the queue. When the receiver stalls,
// the output beat holds, the back end waits, the queue fills and then o_stall rises.
`include "pooling_window_tap_addresser_defines.svh"

module pooling_window_tap_addresser
    import pwta_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_out_col,
    input  logic [7:0]           i_out_row,
    input  logic [7:0]           i_channel,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [INDEX_W-1:0]   o_tap_index,
    output logic                 o_tap_valid,
    output logic                 o_last_tap
);

    t_cfg  r_cfg;
    t_push push;
    t_desc q_head;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width   <= 9'd1;
            r_cfg.image_height  <= 9'd1;
            r_cfg.channel_count <= 9'd1;
            r_cfg.window_width  <= 4'd2;
            r_cfg.window_height <= 4'd2;
            r_cfg.step_x        <= 4'd2;
            r_cfg.step_y        <= 4'd2;
            r_cfg.border_same   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:   r_cfg.image_width   <= i_cfg_data;
                REG_IMAGE_HEIGHT:  r_cfg.image_height  <= i_cfg_data;
                REG_CHANNEL_COUNT: r_cfg.channel_count <= i_cfg_data;
                REG_WINDOW_WIDTH:  r_cfg.window_width  <= i_cfg_data[3:0];
                REG_WINDOW_HEIGHT: r_cfg.window_height <= i_cfg_data[3:0];
                REG_STEP_X:        r_cfg.step_x        <= i_cfg_data[3:0];
                REG_STEP_Y:        r_cfg.step_y        <= i_cfg_data[3:0];
                REG_BORDER_SAME:   r_cfg.border_same   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    pwta_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_valid),
        .i_out_col (i_out_col),
        .i_out_row (i_out_row),
        .i_channel (i_channel),
        .o_stall   (o_stall),
        .o_push    (push),
        .i_q_full  (q_full)
    );

    pwta_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    pwta_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (q_head),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_tap_index (o_tap_index),
        .o_tap_valid (o_tap_valid),
        .o_last_tap  (o_last_tap)
    );

    `PWTA_ASSERT_NOW(a_inv_beat_is_last, o_valid && !o_tap_valid, o_last_tap && (o_tap_index == '0))
    `PWTA_ASSERT_NOW(a_push_has_room, push.valid, !q_full)
    `PWTA_ASSERT_NOW(a_pop_has_entry, q_pop, !q_empty)
    `PWTA_ASSERT_NEXT(a_step_x_write, i_cfg_we && (i_cfg_index == REG_STEP_X), r_cfg.step_x == $past(i_cfg_data[3:0]))

endmodule
